>>> rtl/wfqm_pkg.sv
// wfqm_pkg: shared types and codes for the wlan frame queue manager
// holds the action and tag-source enums, request and register codes
// no dependencies
package wfqm_pkg;

  // fixed field widths of the request and result channels
  localparam int unsigned CatInW    = 2;
  localparam int unsigned ActionW   = 3;
  localparam int unsigned CapW      = 7;
  localparam int unsigned ActCatW   = 3;
  localparam int unsigned TotalOutW = 9;
  localparam int unsigned CfgIdxW   = 1;
  localparam int unsigned CfgDataW  = 7;

  // request kinds
  localparam logic REQ_ENQUEUE = 1'b0;
  localparam logic REQ_FETCH   = 1'b1;

  // configuration register indexes
  localparam logic [CfgIdxW-1:0] CFG_DATA_CAPACITY = 1'b0;
  localparam logic [CfgIdxW-1:0] CFG_ACTIVE_CATS   = 1'b1;

  typedef enum logic [ActionW-1:0] {
    ACT_QUEUED    = 3'd0,
    ACT_SENT      = 3'd1,
    ACT_DROPPED   = 3'd2,
    ACT_DELIVERED = 3'd3,
    ACT_PENDING   = 3'd4
  } action_e;

  // where the result tag comes from
  typedef enum logic [2:0] {
    SRC_INPUT,
    SRC_MGMT,
    SRC_GROUP,
    SRC_UNICAST,
    SRC_NONE
  } tag_src_e;

endpackage

>>> rtl/wlan_frame_queue_manager.sv
// wlan_frame_queue_manager: strict-priority frame tag queues with tail drop
// shared management fifo plus group and unicast fifos per access category
// depends on wfqm_pkg
//
//   channel  | signals                                         | direction
//   ---------+-------------------------------------------------+----------
//   request  | in_valid_i / in_stall_o, req_type_i .. frame_tag_i | in
//   result   | out_valid_o / out_stall_i, action_o .. data_total_o | out
//   config   | cfg_we_i, cfg_idx_i, cfg_wdata_i                 | in
//
// one request per cycle is taken while in_stall_o is low; its result goes
// through the decision stage and memory read, then the output register
// all pointer, count and pending updates happen in the accepting cycle, so
// back-to-back requests see each other's effect with no bubbles
// reset empties all queues and pending counters; the tag stores are not
// cleared, only written entries are ever read
// a stall on the result side backs up through the two stages to in_stall_o
module wlan_frame_queue_manager #(
  parameter int unsigned NUM_CAT     = 4,
  parameter int unsigned DATA_DEPTH  = 64,
  parameter int unsigned MGMT_DEPTH  = 16,
  parameter int unsigned TAG_BITS    = 16,
  parameter int unsigned PENDING_MAX = 255
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  // configuration
  input  logic                              cfg_we_i,
  input  logic [wfqm_pkg::CfgIdxW-1:0]      cfg_idx_i,
  input  logic [wfqm_pkg::CfgDataW-1:0]     cfg_wdata_i,
  // request channel
  input  logic                              in_valid_i,
  output logic                              in_stall_o,
  input  logic                              req_type_i,
  input  logic [wfqm_pkg::CatInW-1:0]       category_i,
  input  logic                              is_mgmt_i,
  input  logic                              is_group_i,
  input  logic [TAG_BITS-1:0]               frame_tag_i,
  // result channel
  output logic                              out_valid_o,
  input  logic                              out_stall_i,
  output logic [wfqm_pkg::ActionW-1:0]      action_o,
  output logic [TAG_BITS-1:0]               out_tag_o,
  output logic [wfqm_pkg::CatInW-1:0]       out_category_o,
  output logic                              out_is_mgmt_o,
  output logic [wfqm_pkg::TotalOutW-1:0]    data_total_o
);

  localparam int unsigned CatW   = (NUM_CAT > 1) ? $clog2(NUM_CAT) : 1;
  localparam int unsigned PtrW   = $clog2(DATA_DEPTH);
  localparam int unsigned CntW   = $clog2(DATA_DEPTH + 1);
  localparam int unsigned MPtrW  = $clog2(MGMT_DEPTH);
  localparam int unsigned MCntW  = $clog2(MGMT_DEPTH + 1);
  localparam int unsigned PendW  = $clog2(PENDING_MAX + 1);
  localparam int unsigned TotW   = $clog2(NUM_CAT * DATA_DEPTH + 1);
  localparam int unsigned TotWx  = (TotW > wfqm_pkg::TotalOutW) ? TotW : wfqm_pkg::TotalOutW;
  localparam int unsigned CmpW   = (CntW + 1 > wfqm_pkg::CapW) ? CntW + 1 : wfqm_pkg::CapW;

  // configuration registers
  logic [wfqm_pkg::CapW-1:0]    cap_q;
  logic [wfqm_pkg::ActCatW-1:0] act_cats_q;

  // queue state
  logic [PtrW-1:0]  grp_head_q [NUM_CAT];
  logic [PtrW-1:0]  grp_tail_q [NUM_CAT];
  logic [CntW-1:0]  grp_cnt_q  [NUM_CAT];
  logic [PtrW-1:0]  uni_head_q [NUM_CAT];
  logic [PtrW-1:0]  uni_tail_q [NUM_CAT];
  logic [CntW-1:0]  uni_cnt_q  [NUM_CAT];
  logic [PendW-1:0] pend_q     [NUM_CAT];
  logic [MPtrW-1:0] mgmt_head_q;
  logic [MPtrW-1:0] mgmt_tail_q;
  logic [MCntW-1:0] mgmt_cnt_q;
  logic [TotWx-1:0] total_q;
  logic [TotWx-1:0] total_d;

  // tag stores
  logic [TAG_BITS-1:0] grp_mem  [NUM_CAT][DATA_DEPTH];
  logic [TAG_BITS-1:0] uni_mem  [NUM_CAT][DATA_DEPTH];
  logic [TAG_BITS-1:0] mgmt_mem [MGMT_DEPTH];
  logic [TAG_BITS-1:0] grp_rd_q;
  logic [TAG_BITS-1:0] uni_rd_q;
  logic [TAG_BITS-1:0] mgmt_rd_q;

  // decision stage register
  logic                        s1_valid_q;
  wfqm_pkg::action_e           s1_action_q;
  wfqm_pkg::tag_src_e          s1_src_q;
  logic [wfqm_pkg::CatInW-1:0] s1_cat_q;
  logic                        s1_mgmt_q;
  logic [TAG_BITS-1:0]         s1_tag_q;
  logic [wfqm_pkg::TotalOutW-1:0] s1_total_q;

  // output register
  logic                        out_valid_q;
  wfqm_pkg::action_e           out_action_q;
  logic [TAG_BITS-1:0]         out_tag_q;
  logic [wfqm_pkg::CatInW-1:0] out_cat_q;
  logic                        out_mgmt_q;
  logic [wfqm_pkg::TotalOutW-1:0] out_total_q;
  logic [TAG_BITS-1:0]         sel_tag;

  // handshake
  logic in_acc;
  logic s1_adv;

  // decision signals
  logic [3:0]                  act_eff;
  logic [wfqm_pkg::CatInW-1:0] cat_eff;
  logic [CatW-1:0]             cat_idx;
  logic [CmpW-1:0]             cap_eff;
  logic [CmpW-1:0]             occ;
  wfqm_pkg::action_e           action_d;
  wfqm_pkg::tag_src_e          src_d;
  logic                        mgmt_d;
  logic push_g, push_u, push_m, pop_g, pop_u, pop_m, pend_dec, pend_inc;

  assign s1_adv     = !out_valid_q || !out_stall_i;
  assign in_stall_o = s1_valid_q && !s1_adv;
  assign in_acc     = in_valid_i && !in_stall_o;

  // effective category: unused categories fold onto category 0
  always_comb begin
    act_eff = {1'b0, act_cats_q};
    if (act_eff == 4'd0) begin
      act_eff = 4'd1;
    end else if (act_eff > 4'(NUM_CAT)) begin
      act_eff = 4'(NUM_CAT);
    end
    cat_eff = ({2'b00, category_i} < act_eff) ? category_i : '0;
    cat_idx = CatW'(cat_eff);
  end

  // capacity: zero or above the store depth means the full depth
  always_comb begin
    if (cap_q == '0 || CmpW'(cap_q) > CmpW'(DATA_DEPTH)) begin
      cap_eff = CmpW'(DATA_DEPTH);
    end else begin
      cap_eff = CmpW'(cap_q);
    end
    occ = CmpW'(grp_cnt_q[cat_idx]) + CmpW'(uni_cnt_q[cat_idx]);
  end

  // request decision
  always_comb begin
    action_d = wfqm_pkg::ACT_QUEUED;
    src_d    = wfqm_pkg::SRC_INPUT;
    mgmt_d   = is_mgmt_i;
    push_g   = 1'b0;
    push_u   = 1'b0;
    push_m   = 1'b0;
    pop_g    = 1'b0;
    pop_u    = 1'b0;
    pop_m    = 1'b0;
    pend_dec = 1'b0;
    pend_inc = 1'b0;
    if (req_type_i == wfqm_pkg::REQ_ENQUEUE) begin
      priority if (pend_q[cat_idx] != '0) begin
        // waiting mac request takes the frame directly
        action_d = wfqm_pkg::ACT_SENT;
        pend_dec = 1'b1;
      end else if (is_mgmt_i) begin
        if (mgmt_cnt_q == MCntW'(MGMT_DEPTH)) begin
          action_d = wfqm_pkg::ACT_DROPPED;
        end else begin
          push_m = 1'b1;
        end
      end else if (occ >= cap_eff) begin
        action_d = wfqm_pkg::ACT_DROPPED;
      end else if (is_group_i) begin
        push_g = 1'b1;
      end else begin
        push_u = 1'b1;
      end
    end else begin
      mgmt_d   = 1'b0;
      action_d = wfqm_pkg::ACT_DELIVERED;
      priority if (mgmt_cnt_q != '0) begin
        pop_m  = 1'b1;
        src_d  = wfqm_pkg::SRC_MGMT;
        mgmt_d = 1'b1;
      end else if (grp_cnt_q[cat_idx] != '0) begin
        pop_g = 1'b1;
        src_d = wfqm_pkg::SRC_GROUP;
      end else if (uni_cnt_q[cat_idx] != '0) begin
        pop_u = 1'b1;
        src_d = wfqm_pkg::SRC_UNICAST;
      end else begin
        // nothing to hand out, remember the request
        action_d = wfqm_pkg::ACT_PENDING;
        src_d    = wfqm_pkg::SRC_NONE;
        pend_inc = (pend_q[cat_idx] < PendW'(PENDING_MAX));
      end
    end
  end

  // running total of held data frames
  always_comb begin
    total_d = total_q;
    if (push_g || push_u) begin
      total_d = total_q + TotWx'(1);
    end else if (pop_g || pop_u) begin
      total_d = total_q - TotWx'(1);
    end
  end

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cap_q      <= '0;
      act_cats_q <= wfqm_pkg::ActCatW'(1);
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        wfqm_pkg::CFG_DATA_CAPACITY: cap_q      <= cfg_wdata_i;
        wfqm_pkg::CFG_ACTIVE_CATS:   act_cats_q <= cfg_wdata_i[wfqm_pkg::ActCatW-1:0];
        default: ;
      endcase
    end
  end

  // pointers, counts and pending counters
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int c = 0; c < NUM_CAT; c++) begin
        grp_head_q[c] <= '0;
        grp_tail_q[c] <= '0;
        grp_cnt_q[c]  <= '0;
        uni_head_q[c] <= '0;
        uni_tail_q[c] <= '0;
        uni_cnt_q[c]  <= '0;
        pend_q[c]     <= '0;
      end
      mgmt_head_q <= '0;
      mgmt_tail_q <= '0;
      mgmt_cnt_q  <= '0;
      total_q     <= '0;
    end else if (in_acc) begin
      total_q <= total_d;
      if (pend_dec) begin
        pend_q[cat_idx] <= pend_q[cat_idx] - PendW'(1);
      end
      if (pend_inc) begin
        pend_q[cat_idx] <= pend_q[cat_idx] + PendW'(1);
      end
      if (push_m) begin
        mgmt_tail_q <= (mgmt_tail_q == MPtrW'(MGMT_DEPTH - 1)) ? '0 : mgmt_tail_q + MPtrW'(1);
        mgmt_cnt_q  <= mgmt_cnt_q + MCntW'(1);
      end
      if (pop_m) begin
        mgmt_head_q <= (mgmt_head_q == MPtrW'(MGMT_DEPTH - 1)) ? '0 : mgmt_head_q + MPtrW'(1);
        mgmt_cnt_q  <= mgmt_cnt_q - MCntW'(1);
      end
      if (push_g) begin
        grp_tail_q[cat_idx] <= (grp_tail_q[cat_idx] == PtrW'(DATA_DEPTH - 1)) ?
                               '0 : grp_tail_q[cat_idx] + PtrW'(1);
        grp_cnt_q[cat_idx]  <= grp_cnt_q[cat_idx] + CntW'(1);
      end
      if (pop_g) begin
        grp_head_q[cat_idx] <= (grp_head_q[cat_idx] == PtrW'(DATA_DEPTH - 1)) ?
                               '0 : grp_head_q[cat_idx] + PtrW'(1);
        grp_cnt_q[cat_idx]  <= grp_cnt_q[cat_idx] - CntW'(1);
      end
      if (push_u) begin
        uni_tail_q[cat_idx] <= (uni_tail_q[cat_idx] == PtrW'(DATA_DEPTH - 1)) ?
                               '0 : uni_tail_q[cat_idx] + PtrW'(1);
        uni_cnt_q[cat_idx]  <= uni_cnt_q[cat_idx] + CntW'(1);
      end
      if (pop_u) begin
        uni_head_q[cat_idx] <= (uni_head_q[cat_idx] == PtrW'(DATA_DEPTH - 1)) ?
                               '0 : uni_head_q[cat_idx] + PtrW'(1);
        uni_cnt_q[cat_idx]  <= uni_cnt_q[cat_idx] - CntW'(1);
      end
    end
  end

  // tag stores: one write and one registered read per cycle each
  always_ff @(posedge clk_i) begin
    if (in_acc && push_g) begin
      grp_mem[cat_idx][grp_tail_q[cat_idx]] <= frame_tag_i;
    end
    if (in_acc && pop_g) begin
      grp_rd_q <= grp_mem[cat_idx][grp_head_q[cat_idx]];
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc && push_u) begin
      uni_mem[cat_idx][uni_tail_q[cat_idx]] <= frame_tag_i;
    end
    if (in_acc && pop_u) begin
      uni_rd_q <= uni_mem[cat_idx][uni_head_q[cat_idx]];
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc && push_m) begin
      mgmt_mem[mgmt_tail_q] <= frame_tag_i;
    end
    if (in_acc && pop_m) begin
      mgmt_rd_q <= mgmt_mem[mgmt_head_q];
    end
  end

  // decision stage control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (in_acc) begin
      s1_valid_q <= 1'b1;
    end else if (s1_adv) begin
      s1_valid_q <= 1'b0;
    end
  end

  // decision stage payload
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      s1_action_q <= action_d;
      s1_src_q    <= src_d;
      s1_cat_q    <= cat_eff;
      s1_mgmt_q   <= mgmt_d;
      s1_tag_q    <= frame_tag_i;
      s1_total_q  <= total_d[wfqm_pkg::TotalOutW-1:0];
    end
  end

  // pick the result tag from the input copy or one of the store reads
  always_comb begin
    unique case (s1_src_q)
      wfqm_pkg::SRC_INPUT:   sel_tag = s1_tag_q;
      wfqm_pkg::SRC_MGMT:    sel_tag = mgmt_rd_q;
      wfqm_pkg::SRC_GROUP:   sel_tag = grp_rd_q;
      wfqm_pkg::SRC_UNICAST: sel_tag = uni_rd_q;
      default:               sel_tag = '0;
    endcase
  end

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (s1_adv) begin
      out_valid_q <= s1_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_adv && s1_valid_q) begin
      out_action_q <= s1_action_q;
      out_tag_q    <= sel_tag;
      out_cat_q    <= s1_cat_q;
      out_mgmt_q   <= s1_mgmt_q;
      out_total_q  <= s1_total_q;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign action_o       = out_action_q;
  assign out_tag_o      = out_tag_q;
  assign out_category_o = out_cat_q;
  assign out_is_mgmt_o  = out_mgmt_q;
  assign data_total_o   = out_total_q;

endmodule

>>> verif/wlan_frame_queue_manager_checker.sv
// wlan_frame_queue_manager_checker: watches the request, result and register ports,
// keeps its own copy of the queues and compares every result field by field
// depends on wfqm_pkg
module wlan_frame_queue_manager_checker (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             cfg_we_i,
  input  logic [wfqm_pkg::CfgIdxW-1:0]     cfg_idx_i,
  input  logic [wfqm_pkg::CfgDataW-1:0]    cfg_wdata_i,
  input  logic                             in_valid_i,
  input  logic                             in_stall_i,
  input  logic                             req_type_i,
  input  logic [wfqm_pkg::CatInW-1:0]      category_i,
  input  logic                             is_mgmt_i,
  input  logic                             is_group_i,
  input  logic [15:0]                      frame_tag_i,
  input  logic                             out_valid_i,
  input  logic                             out_stall_i,
  input  logic [wfqm_pkg::ActionW-1:0]     action_i,
  input  logic [15:0]                      out_tag_i,
  input  logic [wfqm_pkg::CatInW-1:0]      out_category_i,
  input  logic                             out_is_mgmt_i,
  input  logic [wfqm_pkg::TotalOutW-1:0]   data_total_i,
  output int unsigned                      mismatch_count_o,
  output int unsigned                      awaited_count_o
);

  localparam int unsigned NumCat     = 4;
  localparam int unsigned DataDepth  = 64;
  localparam int unsigned MgmtDepth  = 16;
  localparam int unsigned PendingMax = 255;

  typedef struct packed {
    wfqm_pkg::action_e             action;
    logic [15:0]                   tag;
    logic [wfqm_pkg::CatInW-1:0]   cat;
    logic                          mgmt;
    logic [wfqm_pkg::TotalOutW-1:0] total;
  } outcome_t;

  logic [wfqm_pkg::CapW-1:0]    capacity_reg;
  logic [wfqm_pkg::ActCatW-1:0] active_reg;

  logic [15:0]  mgmt_fifo [$];
  logic [15:0]  group_fifo [NumCat][$];
  logic [15:0]  unicast_fifo [NumCat][$];
  int unsigned  pending_cnt [NumCat];
  outcome_t     outcome_q [$];

  function automatic int unsigned stored_data_frames();
    int unsigned sum;
    sum = 0;
    for (int c = 0; c < NumCat; c++) begin
      sum += group_fifo[c].size() + unicast_fifo[c].size();
    end
    return sum;
  endfunction

  task automatic report_mismatch(input string field, input longint unsigned got,
                                 input longint unsigned want);
    mismatch_count_o++;
    $display("checker: %s got %0d expected %0d at %0t", field, got, want, $time);
  endtask

  // one accepted request: update the queue copy and record its outcome
  task automatic apply_request(input logic kind, input logic [1:0] cat_in, input logic mgmt,
                               input logic grp, input logic [15:0] tag);
    int unsigned act_n;
    int unsigned cap;
    logic [1:0]  cat;
    outcome_t    o;
    act_n = active_reg;
    if (act_n == 0) act_n = 1;
    if (act_n > NumCat) act_n = NumCat;
    cap = capacity_reg;
    if (cap == 0 || cap > DataDepth) cap = DataDepth;
    cat = (cat_in >= act_n) ? 2'd0 : cat_in;
    o.cat = cat;
    o.tag = '0;
    o.mgmt = 1'b0;
    if (kind == wfqm_pkg::REQ_ENQUEUE) begin
      o.tag = tag;
      o.mgmt = mgmt;
      if (pending_cnt[cat] > 0) begin
        pending_cnt[cat]--;
        o.action = wfqm_pkg::ACT_SENT;
      end else if (mgmt) begin
        if (mgmt_fifo.size() >= MgmtDepth) begin
          o.action = wfqm_pkg::ACT_DROPPED;
        end else begin
          mgmt_fifo.insert(mgmt_fifo.size(), tag);
          o.action = wfqm_pkg::ACT_QUEUED;
        end
      end else if (group_fifo[cat].size() + unicast_fifo[cat].size() >= cap) begin
        o.action = wfqm_pkg::ACT_DROPPED;
      end else begin
        if (grp) begin
          group_fifo[cat].insert(group_fifo[cat].size(), tag);
        end else begin
          unicast_fifo[cat].insert(unicast_fifo[cat].size(), tag);
        end
        o.action = wfqm_pkg::ACT_QUEUED;
      end
    end else begin
      if (mgmt_fifo.size() > 0) begin
        o.tag = mgmt_fifo[0];
        mgmt_fifo.delete(0);
        o.mgmt = 1'b1;
        o.action = wfqm_pkg::ACT_DELIVERED;
      end else if (group_fifo[cat].size() > 0) begin
        o.tag = group_fifo[cat][0];
        group_fifo[cat].delete(0);
        o.action = wfqm_pkg::ACT_DELIVERED;
      end else if (unicast_fifo[cat].size() > 0) begin
        o.tag = unicast_fifo[cat][0];
        unicast_fifo[cat].delete(0);
        o.action = wfqm_pkg::ACT_DELIVERED;
      end else begin
        if (pending_cnt[cat] < PendingMax) pending_cnt[cat]++;
        o.action = wfqm_pkg::ACT_PENDING;
      end
    end
    o.total = wfqm_pkg::TotalOutW'(stored_data_frames());
    outcome_q.insert(outcome_q.size(), o);
  endtask

  task automatic check_result();
    outcome_t want;
    if (outcome_q.size() == 0) begin
      report_mismatch("result with nothing outstanding, action", action_i, 0);
    end else begin
      want = outcome_q[0];
      outcome_q.delete(0);
      if (action_i !== want.action) report_mismatch("action", action_i, want.action);
      if (out_tag_i !== want.tag) report_mismatch("out_tag", out_tag_i, want.tag);
      if (out_category_i !== want.cat)
        report_mismatch("out_category", out_category_i, want.cat);
      if (out_is_mgmt_i !== want.mgmt) report_mismatch("out_is_mgmt", out_is_mgmt_i, want.mgmt);
      if (data_total_i !== want.total) report_mismatch("data_total", data_total_i, want.total);
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      capacity_reg = '0;
      active_reg = 3'd1;
      mgmt_fifo.delete();
      for (int c = 0; c < NumCat; c++) begin
        group_fifo[c].delete();
        unicast_fifo[c].delete();
        pending_cnt[c] = 0;
      end
      outcome_q.delete();
      mismatch_count_o = 0;
      awaited_count_o = 0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          wfqm_pkg::CFG_DATA_CAPACITY: capacity_reg = cfg_wdata_i;
          wfqm_pkg::CFG_ACTIVE_CATS:   active_reg = cfg_wdata_i[wfqm_pkg::ActCatW-1:0];
          default: ;
        endcase
      end
      if (out_valid_i && !out_stall_i) check_result();
      if (in_valid_i && !in_stall_i) begin
        apply_request(req_type_i, category_i, is_mgmt_i, is_group_i, frame_tag_i);
      end
      awaited_count_o = outcome_q.size();
    end
  end

endmodule

>>> verif/wlan_frame_queue_manager_tb.sv
// wlan_frame_queue_manager_tb: stimulus and verdict for the frame queue manager
// drives requests, results back-pressure and register writes; checking is in the checker
// depends on wfqm_pkg, wlan_frame_queue_manager and wlan_frame_queue_manager_checker
module wlan_frame_queue_manager_tb;

  localparam int unsigned CycleLimit = 500000;  // far above the slowest legal run
  localparam int unsigned HoldCycles = 200;     // long receiver hold-off
  localparam int unsigned MaxGap     = 18;      // longest idle drawn per item
  localparam int unsigned DrainExtra = 4;       // two-stage pipe plus margin

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  // register port
  logic                          cfg_we = 1'b0;
  logic [wfqm_pkg::CfgIdxW-1:0]  cfg_idx = '0;
  logic [wfqm_pkg::CfgDataW-1:0] cfg_wdata = '0;

  // request channel
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic        req_type = wfqm_pkg::REQ_ENQUEUE;
  logic [1:0]  category = '0;
  logic        is_mgmt = 1'b0;
  logic        is_group = 1'b0;
  logic [15:0] frame_tag = '0;

  // result channel
  logic                           out_valid;
  logic                           out_stall = 1'b0;
  logic [wfqm_pkg::ActionW-1:0]   action;
  logic [15:0]                    out_tag;
  logic [1:0]                     out_category;
  logic                           out_is_mgmt;
  logic [wfqm_pkg::TotalOutW-1:0] data_total;

  int unsigned mismatch_count;
  int unsigned awaited_count;
  int unsigned cycle_count = 0;

  // sender pacing: the idle range changes every few dozen requests, including 0
  int unsigned sender_gap_max = 0;
  int unsigned sends_left_in_mode = 0;

  // receiver pacing, and hold-off requests handed from the stimulus process
  int unsigned hold_requests = 0;
  int unsigned holds_served = 0;
  int unsigned hold_left = 0;
  int unsigned stall_left = 0;
  int unsigned stall_max = 0;
  int unsigned results_left_in_mode = 0;

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  wlan_frame_queue_manager DUT (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we),
    .cfg_idx_i      (cfg_idx),
    .cfg_wdata_i    (cfg_wdata),
    .in_valid_i     (in_valid),
    .in_stall_o     (in_stall),
    .req_type_i     (req_type),
    .category_i     (category),
    .is_mgmt_i      (is_mgmt),
    .is_group_i     (is_group),
    .frame_tag_i    (frame_tag),
    .out_valid_o    (out_valid),
    .out_stall_i    (out_stall),
    .action_o       (action),
    .out_tag_o      (out_tag),
    .out_category_o (out_category),
    .out_is_mgmt_o  (out_is_mgmt),
    .data_total_o   (data_total)
  );

  wlan_frame_queue_manager_checker result_checker (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_we_i         (cfg_we),
    .cfg_idx_i        (cfg_idx),
    .cfg_wdata_i      (cfg_wdata),
    .in_valid_i       (in_valid),
    .in_stall_i       (in_stall),
    .req_type_i       (req_type),
    .category_i       (category),
    .is_mgmt_i        (is_mgmt),
    .is_group_i       (is_group),
    .frame_tag_i      (frame_tag),
    .out_valid_i      (out_valid),
    .out_stall_i      (out_stall),
    .action_i         (action),
    .out_tag_i        (out_tag),
    .out_category_i   (out_category),
    .out_is_mgmt_i    (out_is_mgmt),
    .data_total_i     (data_total),
    .mismatch_count_o (mismatch_count),
    .awaited_count_o  (awaited_count)
  );

  // result side: one stall draw per taken result, plus long hold-offs on demand
  always @(posedge clk_i) begin
    if (holds_served != hold_requests) begin
      holds_served++;
      hold_left = HoldCycles;
    end
    if (out_valid && !out_stall) begin  // result taken at this edge
      if (results_left_in_mode == 0) begin
        case ($urandom_range(0, 2))
          0:       stall_max = 0;
          1:       stall_max = 4;
          default: stall_max = MaxGap;
        endcase
        results_left_in_mode = $urandom_range(20, 60);
      end
      results_left_in_mode--;
      stall_left = $urandom_range(0, stall_max);
    end
    if (hold_left != 0) begin
      hold_left--;
      out_stall <= 1'b1;
    end else if (stall_left != 0) begin
      stall_left--;
      out_stall <= 1'b1;
    end else begin
      out_stall <= 1'b0;
    end
  end

  // watchdog
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CycleLimit) begin
      $display("tb: failure");
      $finish;
    end
  end

  // offer one request and return at the edge that takes it; valid stays high
  // so a back-to-back request needs no second assignment in the same step
  task automatic offer_request(input logic kind, input logic [1:0] cat, input logic mgmt,
                               input logic grp, input logic [15:0] tag);
    int unsigned gap;
    if (sends_left_in_mode == 0) begin
      case ($urandom_range(0, 2))
        0:       sender_gap_max = 0;
        1:       sender_gap_max = 3;
        default: sender_gap_max = MaxGap;
      endcase
      sends_left_in_mode = $urandom_range(20, 60);
    end
    sends_left_in_mode--;
    gap = $urandom_range(0, sender_gap_max);
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid  <= 1'b1;
    req_type  <= kind;
    category  <= cat;
    is_mgmt   <= mgmt;
    is_group  <= grp;
    frame_tag <= tag;
    do @(posedge clk_i); while (in_stall);
  endtask

  // random requests: enq_pct percent enqueues, mgmt_pct percent of them management
  task automatic offer_random(input int unsigned count, input int unsigned enq_pct,
                              input int unsigned mgmt_pct);
    logic kind;
    logic mgmt;
    repeat (count) begin
      kind = ($urandom_range(0, 99) < enq_pct) ? wfqm_pkg::REQ_ENQUEUE : wfqm_pkg::REQ_FETCH;
      mgmt = ($urandom_range(0, 99) < mgmt_pct);
      offer_request(kind, 2'($urandom_range(0, 3)), mgmt, 1'($urandom_range(0, 1)),
                    16'($urandom));
    end
  endtask

  // receiver holds off while the sender streams with no idle, so the block
  // backs up and stalls its request side
  task automatic press_input();
    hold_requests++;
    sender_gap_max = 0;
    sends_left_in_mode = 40;
  endtask

  // wait until every request has produced its result, then let the pipe settle
  task automatic wait_for_drain();
    in_valid <= 1'b0;
    @(posedge clk_i);
    while (awaited_count != 0) @(posedge clk_i);
    repeat (DrainExtra) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [wfqm_pkg::CfgIdxW-1:0] idx,
                           input logic [wfqm_pkg::CfgDataW-1:0] value);
    cfg_we    <= 1'b1;
    cfg_idx   <= idx;
    cfg_wdata <= value;
    @(posedge clk_i);
    cfg_we <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic configure(input logic [wfqm_pkg::CfgDataW-1:0] capacity,
                           input logic [wfqm_pkg::CfgDataW-1:0] cats);
    wait_for_drain();
    write_reg(wfqm_pkg::CFG_DATA_CAPACITY, capacity);
    write_reg(wfqm_pkg::CFG_ACTIVE_CATS, cats);
  endtask

  initial begin
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed part, reset setup: one category, full depth
    // request on an empty queue goes pending, next frame is sent at once
    offer_request(wfqm_pkg::REQ_FETCH, 2'd2, 1'b0, 1'b0, 16'h0000);
    offer_request(wfqm_pkg::REQ_ENQUEUE, 2'd1, 1'b1, 1'b0, 16'hFFFF);
    offer_request(wfqm_pkg::REQ_FETCH, 2'd0, 1'b1, 1'b1, 16'hFFFF);
    offer_request(wfqm_pkg::REQ_ENQUEUE, 2'd3, 1'b0, 1'b0, 16'h0000);
    // fill the management queue and overflow it by one
    for (int i = 0; i < 17; i++) begin
      offer_request(wfqm_pkg::REQ_ENQUEUE, 2'(i), 1'b1, 1'(i), 16'hFFFF ^ 16'(i * 16'h1111));
    end
    // unused category folds to 0; group and unicast frames wait behind management
    offer_request(wfqm_pkg::REQ_ENQUEUE, 2'd3, 1'b0, 1'b1, 16'h8001);
    offer_request(wfqm_pkg::REQ_ENQUEUE, 2'd0, 1'b0, 1'b0, 16'h7FFE);
    offer_request(wfqm_pkg::REQ_FETCH, 2'd0, 1'b0, 1'b0, 16'h0000);

    // small capacity across all categories
    configure(7'd4, 7'd4);
    press_input();
    offer_random(120, 60, 15);

    // single-frame capacity, two categories: upper ones fold onto 0
    configure(7'd1, 7'd2);
    offer_random(100, 55, 20);

    // zero capacity means full depth, too many categories clamp; fill up
    configure(7'd0, 7'd7);
    press_input();
    offer_random(300, 90, 3);

    // capacity above depth, active count 0 in the low bits: everything on
    // category 0 while the others keep their frames; request storm drives the
    // pending counter into saturation, then frames drain it
    configure(7'd127, 7'h78);
    offer_random(340, 0, 0);
    press_input();
    offer_random(270, 100, 0);

    // capacity lowered below occupancy, parked categories come back
    configure(7'd2, 7'd3);
    press_input();
    offer_random(120, 50, 25);

    configure(7'd5, 7'd4);
    offer_random(120, 35, 20);

    wait_for_drain();
    if (mismatch_count == 0 && awaited_count == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

>>> wlan_frame_queue_manager.f
rtl/wfqm_pkg.sv
rtl/wlan_frame_queue_manager.sv
verif/wlan_frame_queue_manager_checker.sv
verif/wlan_frame_queue_manager_tb.sv
